// ----- hw/rtl/vfc_pkg.sv -----
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants for the video frame CRC-32
// Widths, the state and result word layouts, queue sizing and the
// byte-wise MSB-first CRC fold.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int unsigned CrcW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 2;

  // result queue sizing
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CrcW-1:0]  PolyReset   = 32'h04C1_1DB7;
  localparam logic [AddrW-1:0] RegPolyAddr = '0;

  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic [CntW-1:0] frames;
  } state_t;

  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic [CntW-1:0] number;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eop;
    logic             eof;
  } word_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             pop;
  } q_status_t;

  // One byte into the CRC, eight shift steps, MSB first.
  function automatic logic [CrcW-1:0] crc_fold_byte(
    input logic [CrcW-1:0]  crc,
    input logic [ByteW-1:0] byte_in,
    input logic [CrcW-1:0]  poly
  );
    logic [CrcW-1:0] r;
    r = crc ^ {byte_in, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      if (r[CrcW-1]) begin
        r = {r[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CrcW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/vfc_crc_unit.sv -----
// ----------------------------------------------------------------------------
// vfc_crc_unit: state update for one word
// Folds the byte, applies the plane/frame inversion, bumps the frame count.
// ----------------------------------------------------------------------------
module vfc_crc_unit (
  input  vfc_pkg::state_t             cur,
  input  vfc_pkg::word_t              word_in,
  input  logic [vfc_pkg::CrcW-1:0]    poly,
  output vfc_pkg::state_t             nxt,
  output vfc_pkg::result_t            res
);

  logic [vfc_pkg::CrcW-1:0] folded;
  logic [vfc_pkg::CrcW-1:0] marked;
  logic [vfc_pkg::CntW-1:0] frames_inc;

  always_comb begin
    folded     = vfc_pkg::crc_fold_byte(cur.crc, word_in.data, poly);
    // both marks on one byte still invert once
    marked     = (word_in.eop || word_in.eof) ? ~folded : folded;
    frames_inc = cur.frames + vfc_pkg::CntW'(1);

    res.crc    = marked;
    res.number = frames_inc;

    if (word_in.eof) begin
      nxt.crc    = '0;
      nxt.frames = frames_inc;
    end else begin
      nxt.crc    = marked;
      nxt.frames = cur.frames;
    end
  end

endmodule

// ----- hw/rtl/vfc_state_ram.sv -----
// ----------------------------------------------------------------------------
// vfc_state_ram: single-entry state store, registered read
// Read returns the value before a write at the same edge; reads as zero
// until first written.
// ----------------------------------------------------------------------------
module vfc_state_ram (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  vfc_pkg::state_t wdata,
  input  logic            re,
  output vfc_pkg::state_t rdata
);

  vfc_pkg::state_t mem [1];
  vfc_pkg::state_t rd_raw;
  logic            written;
  logic            rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= 1'b0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written <= 1'b1;
      end
      if (re) begin
        rd_written <= written;
      end
    end
  end

  assign rdata = rd_written ? rd_raw : '0;

endmodule

// ----- hw/rtl/vfc_out_queue.sv -----
// ----------------------------------------------------------------------------
// vfc_out_queue: small result queue in front of the output channel
// Decouples the state update from output stall.
// ----------------------------------------------------------------------------
module vfc_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vfc_pkg::result_t    push_data,
  input  logic                out_stall,
  output logic                out_valid,
  output vfc_pkg::result_t    head,
  output vfc_pkg::q_status_t  status
);

  vfc_pkg::result_t             slot [vfc_pkg::QDepth];
  logic [vfc_pkg::QPtrW-1:0]    wr_ptr;
  logic [vfc_pkg::QPtrW-1:0]    rd_ptr;
  logic [vfc_pkg::QCntW-1:0]    count;
  logic                         pop;

  assign out_valid    = (count != '0);
  assign pop          = out_valid && !out_stall;
  assign head         = slot[rd_ptr];
  assign status.count = count;
  assign status.pop   = pop;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == vfc_pkg::QPtrW'(vfc_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == vfc_pkg::QPtrW'(vfc_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + vfc_pkg::QCntW'(push) - vfc_pkg::QCntW'(pop);
    end
  end

endmodule

// ----- hw/rtl/video_frame_crc32.sv -----
// ----------------------------------------------------------------------------
// video_frame_crc32: per-frame CRC-32 over a byte stream
// One byte per input word; a result word per completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries data_byte with end_of_plane and
//   end_of_frame marks. Each byte is folded MSB-first into a 32-bit CRC with
//   the programmed polynomial, start value zero. A plane or frame mark
//   inverts the CRC after its byte (once, if both are set).
//   An end_of_frame word yields one output word (frame_crc, frame_number)
//   and clears the CRC; frame_number counts from 1 and wraps.
//   Throughput: one byte per cycle while in_stall is low. A result goes from
//   its end_of_frame byte through stage 1 and the result queue to the output,
//   along the read-modify-write loop on the state memory: read issued at
//   accept, fold and write back in the next cycle, with the last write
//   forwarded so back-to-back bytes see the fresh state.
//   Stall: results wait in a two-word queue; in_stall rises only when that
//   queue could overflow, so input keeps flowing while one result waits.
//   Reset: rst (synchronous) clears CRC, frame count, queue and pipeline and
//   loads the polynomial 0x04C11DB7. Config via APB at byte address 0;
//   write only while idle.
// ----------------------------------------------------------------------------
module video_frame_crc32 (
  input  logic                          clk,
  input  logic                          rst,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vfc_pkg::AddrW-1:0]     paddr,
  input  logic [vfc_pkg::DataW-1:0]     pwdata,
  output logic [vfc_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vfc_pkg::ByteW-1:0]     data_byte,
  input  logic                          end_of_plane,
  input  logic                          end_of_frame,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vfc_pkg::CrcW-1:0]      frame_crc,
  output logic [vfc_pkg::CntW-1:0]      frame_number
);

  logic [vfc_pkg::CrcW-1:0] polynomial;

  logic                 in_acc;
  logic                 s1_valid;
  vfc_pkg::word_t       s1_word;

  vfc_pkg::state_t      ram_rdata;
  vfc_pkg::state_t      fwd_data;
  logic                 fwd_valid;
  vfc_pkg::state_t      cur;
  vfc_pkg::state_t      nxt;
  vfc_pkg::result_t     res;
  logic                 wr_en;

  logic                 push;
  vfc_pkg::result_t     q_head;
  vfc_pkg::q_status_t   q_status;
  logic [vfc_pkg::QCntW:0] q_level;

  // ---- configuration ----
  assign pready = 1'b1;
  assign prdata = (paddr == vfc_pkg::RegPolyAddr) ? polynomial : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= vfc_pkg::PolyReset;
    end else if (psel && penable && pwrite && pready && (paddr == vfc_pkg::RegPolyAddr)) begin
      polynomial <= pwdata;
    end
  end

  // ---- flow control ----
  // Queue level after this edge, counting a result due from stage 1. A
  // newly accepted word can push once it leaves stage 1, so keep one slot free.
  always_comb begin
    q_level  = (vfc_pkg::QCntW+1)'(q_status.count)
             - (vfc_pkg::QCntW+1)'(q_status.pop)
             + (vfc_pkg::QCntW+1)'(s1_valid && s1_word.eof);
    in_stall = (q_level > (vfc_pkg::QCntW+1)'(vfc_pkg::QDepth - 1));
  end

  assign in_acc = in_valid && !in_stall;

  // ---- stage 0: accept, issue state read ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word.data <= data_byte;
      s1_word.eop  <= end_of_plane;
      s1_word.eof  <= end_of_frame;
    end
  end

  vfc_state_ram u_state (
    .clk   (clk),
    .rst   (rst),
    .we    (wr_en),
    .wdata (nxt),
    .re    (in_acc),
    .rdata (ram_rdata)
  );

  // ---- stage 1: modify and write back ----
  // The read sampled at the same edge as the previous write misses it;
  // take the forwarded copy instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data <= nxt;
    end
  end

  assign cur   = fwd_valid ? fwd_data : ram_rdata;
  assign wr_en = s1_valid;
  assign push  = s1_valid && s1_word.eof;

  vfc_crc_unit u_crc (
    .cur     (cur),
    .word_in (s1_word),
    .poly    (polynomial),
    .nxt     (nxt),
    .res     (res)
  );

  // ---- result queue ----
  vfc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (q_head),
    .status    (q_status)
  );

  assign frame_crc    = q_head.crc;
  assign frame_number = q_head.number;

  // ---- checks ----
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= vfc_pkg::QCntW'(vfc_pkg::QDepth))
    else $error("result queue overflow");

  a_frame_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && end_of_frame) |-> ##2 out_valid)
    else $error("frame end produced no result word");

  a_write_back: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> wr_en)
    else $error("accepted word missed its state write-back");

endmodule
